FILE: sv/salc_pkg.sv
// Shared constants, types and command struct for the cache tag model.
package salc_pkg;
	localparam int SETS       = 256;
	localparam int WAYS       = 8;
	localparam int ADDR_W     = 32;
	localparam int SET_W      = $clog2(SETS);
	localparam int WAY_W      = $clog2(WAYS);
	localparam int CNT_W      = 32;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INDEX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS   = 2'd2;

	localparam logic [1:0] FUNC_READ  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_FETCH = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	typedef logic [WAY_W-1:0] way_t;

	typedef struct packed {
		logic [WAYS-1:0][ADDR_W-1:0] tag;
		logic [WAYS-1:0]             valid;
		logic [WAYS-1:0]             dirty;
		way_t [WAYS-1:0]             lru;
	} row_t;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;
endpackage

FILE: sv/salc_ctrl.sv
// Controller: lookup sequencing and output handshake.
module salc_ctrl import salc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);
	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_LOOKUP = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = in_ready && in_valid;
	assign cmd.commit = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load)
						state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					if (cmd.commit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

FILE: sv/salc_dp.sv
// Datapath: set memory, tag compare, LRU update and totals.
module salc_dp import salc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic              cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [ADDR_W-1:0] address,
	input  logic [1:0]        func,
	output logic              hit,
	output logic              writeback,
	output logic [2:0]        way_used,
	output logic [CNT_W-1:0]  access_count,
	output logic [CNT_W-1:0]  hit_count,
	output logic [CNT_W-1:0]  miss_count,
	output logic [CNT_W-1:0]  writeback_count
);
	row_t mem [SETS];

	logic [CFG_W-1:0]  offset_q, index_q, ways_q;
	logic [SETS-1:0]   rowv_q;
	row_t              rd_s1;
	logic              rowv_s1;
	logic [SET_W-1:0]  set_s1;
	logic [ADDR_W-1:0] tag_s1;
	logic [1:0]        func_s1;
	logic [CFG_W-1:0]  n_s1;
	logic              hit_q, wb_q;
	way_t              way_q;
	logic [CNT_W-1:0]  acc_q, hitc_q, missc_q, wbc_q;

	logic [CFG_W-1:0]  ib, n_in;
	logic [SET_W-1:0]  set_in;
	logic [ADDR_W-1:0] tag_in;
	logic [ADDR_W-1:0] shifted;

	always_comb begin
		ib = (index_q > CFG_W'(SET_W)) ? CFG_W'(SET_W) : index_q;
		n_in = (ways_q == '0) ? CFG_W'(1) :
			(ways_q > CFG_W'(WAYS)) ? CFG_W'(WAYS) : ways_q;
		shifted = address >> offset_q;
		set_in = SET_W'(shifted & ((ADDR_W'(1) << ib) - ADDR_W'(1)));
		tag_in = address >> (5'(offset_q) + 5'(ib));
	end

	// Lookup on the row read out
	row_t cur, nxt;
	logic found, is_hit, wb_c;
	way_t stop_w, vic, way_c;
	logic [WAY_W:0] pos;

	always_comb begin
		cur = rd_s1;
		if (!rowv_s1) begin
			cur.valid = '0;
			cur.dirty = '0;
			for (int p = 0; p < WAYS; p++)
				cur.lru[p] = way_t'(p);
		end
		found  = 1'b0;
		stop_w = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if ((CFG_W'(w) < n_s1) && (!cur.valid[w] || cur.tag[w] == tag_s1)) begin
				found  = 1'b1;
				stop_w = way_t'(w);
			end
		end
		is_hit = found && cur.valid[stop_w];
		vic = '0;
		for (int p = 0; p < WAYS; p++)
			if (CFG_W'(cur.lru[p]) < n_s1)
				vic = cur.lru[p];
		way_c = found ? stop_w : vic;
		wb_c  = !found && cur.dirty[vic];
		pos = (WAY_W+1)'(WAYS - 1);
		for (int p = WAYS - 2; p >= 0; p--)
			if (cur.lru[p] == way_c)
				pos = (WAY_W+1)'(p);
		nxt = cur;
		nxt.lru[0] = way_c;
		for (int p = 1; p < WAYS; p++)
			if ((WAY_W+1)'(p) <= pos)
				nxt.lru[p] = cur.lru[p-1];
		if (is_hit) begin
			if (func_s1 == FUNC_WRITE)
				nxt.dirty[way_c] = 1'b1;
		end else begin
			nxt.valid[way_c] = 1'b1;
			nxt.tag[way_c]   = tag_s1;
			nxt.dirty[way_c] = (func_s1 == FUNC_WRITE);
		end
	end

	logic lookup;
	assign lookup = (func_s1 != FUNC_NONE);

	always_ff @(posedge clk) begin
		if (cmd.load)
			rd_s1 <= mem[set_in];
		if (cmd.commit && lookup)
			mem[set_s1] <= nxt;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			set_s1  <= set_in;
			tag_s1  <= tag_in;
			func_s1 <= func;
			n_s1    <= n_in;
		end
	end

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + CNT_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= CFG_W'(4);
			index_q  <= CFG_W'(6);
			ways_q   <= CFG_W'(4);
			rowv_q   <= '0;
			rowv_s1  <= 1'b0;
			hit_q    <= 1'b0;
			wb_q     <= 1'b0;
			way_q    <= '0;
			acc_q    <= '0;
			hitc_q   <= '0;
			missc_q  <= '0;
			wbc_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OFFSET: offset_q <= cfg_data;
					REG_INDEX:  index_q  <= cfg_data;
					REG_WAYS:   ways_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load)
				rowv_s1 <= rowv_q[set_in];
			if (cmd.commit) begin
				acc_q <= sat_inc(acc_q);
				if (lookup) begin
					rowv_q[set_s1] <= 1'b1;
					hit_q <= is_hit;
					wb_q  <= wb_c;
					way_q <= way_c;
					if (is_hit)
						hitc_q <= sat_inc(hitc_q);
					else
						missc_q <= sat_inc(missc_q);
					if (wb_c)
						wbc_q <= sat_inc(wbc_q);
				end else begin
					hit_q <= 1'b0;
					wb_q  <= 1'b0;
					way_q <= '0;
				end
			end
		end
	end

	assign hit             = hit_q;
	assign writeback       = wb_q;
	assign way_used        = 3'(way_q);
	assign access_count    = acc_q;
	assign hit_count       = hitc_q;
	assign miss_count      = missc_q;
	assign writeback_count = wbc_q;
endmodule

FILE: sv/set_assoc_lru_cache_tag_model_top.sv
// Set-associative LRU cache tag model, top level.
// The set row is read into a register, then the result is loaded into the output
// register once that is empty or being taken (set row read, then read-modify-write).
// Input ready again once the result is loaded into the output register.
// Reset: per-set flags give invalid, clean rows, default LRU order; no clearing pass.
// Reset also restores the configuration registers and clears the totals.
module set_assoc_lru_cache_tag_model_top import salc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ADDR_W-1:0] address,
	input  logic [1:0]        func,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              hit,
	output logic              writeback,
	output logic [2:0]        way_used,
	output logic [CNT_W-1:0]  access_count,
	output logic [CNT_W-1:0]  hit_count,
	output logic [CNT_W-1:0]  miss_count,
	output logic [CNT_W-1:0]  writeback_count
);
	cmd_t cmd;

	salc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd)
	);

	salc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.address(address), .func(func),
		.hit(hit), .writeback(writeback), .way_used(way_used),
		.access_count(access_count), .hit_count(hit_count),
		.miss_count(miss_count), .writeback_count(writeback_count)
	);
endmodule
